>>> design/ttc_pkg.sv
// Shared types, constants and the divider step for the tile id to tileset coordinate block.
`timescale 1ns / 1ps

package ttc_pkg;

	localparam int ID_W    = 16;
	localparam int COL_W   = 8;
	localparam int SIZE_W  = 8;
	localparam int MAP_W   = 8;
	localparam int PIX_W   = 16;
	localparam int CFG_W   = 16;
	// one quotient bit per divider stage
	localparam int DIV_STEPS = ID_W;

	typedef enum logic [2:0] {
		REG_BASE_COLUMNS      = 3'd0,
		REG_BASE_TILE_SIZE    = 3'd1,
		REG_SECOND_ENABLE     = 3'd2,
		REG_SECOND_FIRST_ID   = 3'd3,
		REG_SECOND_LAST_ID    = 3'd4,
		REG_SECOND_TILE_COUNT = 3'd5,
		REG_SECOND_COLUMNS    = 3'd6,
		REG_SECOND_TILE_SIZE  = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [ID_W-1:0]  tile_id;
		logic [MAP_W-1:0] map_row;
		logic [MAP_W-1:0] map_col;
	} cell_t;

	typedef struct packed {
		logic             visible;
		logic             tileset_select;
		logic [ID_W-1:0]  source_row;
		logic [COL_W-1:0] source_col;
		logic [PIX_W-1:0] screen_x;
		logic [PIX_W-1:0] screen_y;
	} tile_t;

	// decoded cell, stage 1
	typedef struct packed {
		logic              vis;
		logic              sel;
		logic [COL_W-1:0]  cols;
		logic [ID_W-1:0]   num;
		logic [SIZE_W-1:0] size;
		logic [MAP_W-1:0]  map_row;
		logic [MAP_W-1:0]  map_col;
	} dec_t;

	// divider stage: nq shifts numerator out at the top and quotient in at the bottom
	typedef struct packed {
		logic             vis;
		logic             sel;
		logic [COL_W-1:0] cols;
		logic [ID_W-1:0]  nq;
		logic [COL_W-1:0] rem;
		logic [PIX_W-1:0] sx;
		logic [PIX_W-1:0] sy;
	} step_t;

	// one restoring division step
	function automatic step_t div_step(input step_t p);
		step_t          r;
		logic [COL_W:0] trial;
		logic           qbit;
		r     = p;
		trial = {p.rem, p.nq[ID_W-1]};
		qbit  = 1'b0;
		if (trial >= {1'b0, p.cols}) begin
			trial = trial - {1'b0, p.cols};
			qbit  = 1'b1;
		end
		r.rem = trial[COL_W-1:0];
		r.nq  = {p.nq[ID_W-2:0], qbit};
		return r;
	endfunction

endpackage

>>> design/tile_id_to_tileset_coords.sv
// Top level: map cell to tileset source row/column and screen position, deep pipeline.
`timescale 1ns / 1ps

// Channel  Dir  Handshake               Payload
// cell     in   cell_valid / cell_stall  map_cell: ttc_pkg::cell_t (tile_id, map_row, map_col)
// tile     out  tile_valid / tile_stall  tile: ttc_pkg::tile_t (visible .. screen_y)
// cfg      in   cfg_we                  cfg_index, cfg_data (16 bits)
//
// One cell per cycle while the output is not stalled. Stage 1 decodes and
// remaps the id, stage 2 multiplies the screen position and takes the first
// quotient bit, then one quotient bit per stage of the restoring divider.
// Each stage advances when its successor is empty or advancing, so bubbles
// collapse and a stalled output holds while earlier stages keep filling.
// arst_n clears the valid bits and sets the config registers to their defaults.
module tile_id_to_tileset_coords #(
	parameter int ID_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cell_valid,
	output logic              cell_stall,
	input  ttc_pkg::cell_t    map_cell,
	output logic              tile_valid,
	input  logic              tile_stall,
	output ttc_pkg::tile_t    tile,
	input  logic              cfg_we,
	input  ttc_pkg::cfg_reg_t cfg_index,
	input  logic [ttc_pkg::CFG_W-1:0] cfg_data
);
	import ttc_pkg::*;

	// ids wider than the 16-bit field change nothing; narrower ones mask
	localparam int IDW = (ID_BITS < ID_W) ? ID_BITS : ID_W;
	localparam logic [ID_W-1:0] ID_MASK = ID_W'((33'd1 << IDW) - 33'd1);

	// configuration registers
	logic [COL_W-1:0]  base_columns_q;
	logic [SIZE_W-1:0] base_tile_size_q;
	logic              second_enable_q;
	logic [ID_W-1:0]   second_first_id_q;
	logic [ID_W-1:0]   second_last_id_q;
	logic [ID_W-1:0]   second_tile_count_q;
	logic [COL_W-1:0]  second_columns_q;
	logic [SIZE_W-1:0] second_tile_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_columns_q      <= COL_W'(1);
			base_tile_size_q    <= SIZE_W'(16);
			second_enable_q     <= 1'b0;
			second_first_id_q   <= '0;
			second_last_id_q    <= '0;
			second_tile_count_q <= '0;
			second_columns_q    <= COL_W'(1);
			second_tile_size_q  <= SIZE_W'(16);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BASE_COLUMNS:      base_columns_q      <= cfg_data[COL_W-1:0];
				REG_BASE_TILE_SIZE:    base_tile_size_q    <= cfg_data[SIZE_W-1:0];
				REG_SECOND_ENABLE:     second_enable_q     <= cfg_data[0];
				REG_SECOND_FIRST_ID:   second_first_id_q   <= cfg_data[ID_W-1:0];
				REG_SECOND_LAST_ID:    second_last_id_q    <= cfg_data[ID_W-1:0];
				REG_SECOND_TILE_COUNT: second_tile_count_q <= cfg_data[ID_W-1:0];
				REG_SECOND_COLUMNS:    second_columns_q    <= cfg_data[COL_W-1:0];
				REG_SECOND_TILE_SIZE:  second_tile_size_q  <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// ---- stage 1: select tileset, remap id, form numerator id-1 ----
	// row = (eff-1) / cols and col = (eff-1) % cols cover the last-column case.
	logic [ID_W-1:0] id_m, first_m, last_m;
	logic            in_second;
	logic [ID_W:0]   diff, left;
	dec_t            dec_d;

	always_comb begin
		id_m      = map_cell.tile_id & ID_MASK;
		first_m   = second_first_id_q & ID_MASK;
		last_m    = second_last_id_q & ID_MASK;
		in_second = second_enable_q && (id_m > first_m) && (id_m < last_m);
		diff      = {1'b0, last_m} - {1'b0, id_m};
		// remapped id = count - (last - id); positive only if count > diff
		left      = {1'b0, second_tile_count_q} - diff;

		dec_d.map_row = map_cell.map_row;
		dec_d.map_col = map_cell.map_col;
		dec_d.sel     = in_second;
		if (in_second) begin
			dec_d.cols = second_columns_q;
			dec_d.size = second_tile_size_q;
			dec_d.num  = ID_W'(left - 17'd1);
			dec_d.vis  = ({1'b0, second_tile_count_q} > diff);
		end else begin
			dec_d.cols = base_columns_q;
			dec_d.size = base_tile_size_q;
			dec_d.num  = id_m - ID_W'(1);
			dec_d.vis  = 1'b1;
		end
		if (id_m == '0 || dec_d.cols == '0) begin
			dec_d.vis = 1'b0;
		end
		// not drawn: every field zero, divide 0 by 1
		if (!dec_d.vis) begin
			dec_d.sel  = 1'b0;
			dec_d.cols = COL_W'(1);
			dec_d.size = '0;
			dec_d.num  = '0;
		end
	end

	logic  valid_s1;
	dec_t  dec_s1;
	logic  mv_s1;

	// divider stages: step_s[0] is stage 2, step_s[DIV_STEPS-1] drives the output
	logic  [DIV_STEPS-1:0] step_vld_s;
	step_t                 step_s [DIV_STEPS];
	logic  [DIV_STEPS-1:0] mv;
	step_t                 entry;

	// advance chain from the output back
	always_comb begin
		mv[DIV_STEPS-1] = !step_vld_s[DIV_STEPS-1] || !tile_stall;
		for (int k = DIV_STEPS - 2; k >= 0; k--) begin
			mv[k] = !step_vld_s[k] || mv[k+1];
		end
		mv_s1 = !valid_s1 || mv[0];
	end

	assign cell_stall = !mv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (mv_s1) begin
			valid_s1 <= cell_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (mv_s1 && cell_valid) begin
			dec_s1 <= dec_d;
		end
	end

	// ---- stage 2: screen position products and the first quotient bit ----
	always_comb begin
		entry.vis  = dec_s1.vis;
		entry.sel  = dec_s1.sel;
		entry.cols = dec_s1.cols;
		entry.nq   = dec_s1.num;
		entry.rem  = '0;
		entry.sx   = PIX_W'(dec_s1.map_col) * PIX_W'(dec_s1.size);
		entry.sy   = PIX_W'(dec_s1.map_row) * PIX_W'(dec_s1.size);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_vld_s[0] <= 1'b0;
		end else if (mv[0]) begin
			step_vld_s[0] <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (mv[0] && valid_s1) begin
			step_s[0] <= div_step(entry);
		end
	end

	// ---- stages 3 onward: one quotient bit each ----
	for (genvar g = 1; g < DIV_STEPS; g++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				step_vld_s[g] <= 1'b0;
			end else if (mv[g]) begin
				step_vld_s[g] <= step_vld_s[g-1];
			end
		end

		always_ff @(posedge clk) begin
			if (mv[g] && step_vld_s[g-1]) begin
				step_s[g] <= div_step(step_s[g-1]);
			end
		end
	end

	// ---- output ----
	assign tile_valid          = step_vld_s[DIV_STEPS-1];
	assign tile.visible        = step_s[DIV_STEPS-1].vis;
	assign tile.tileset_select = step_s[DIV_STEPS-1].sel;
	assign tile.source_row     = step_s[DIV_STEPS-1].nq;
	assign tile.source_col     = step_s[DIV_STEPS-1].rem;
	assign tile.screen_x       = step_s[DIV_STEPS-1].sx;
	assign tile.screen_y       = step_s[DIV_STEPS-1].sy;

`ifndef ASSERT_OFF
	// a hidden tile carries all-zero fields
	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		tile_valid && !tile.visible |-> !tile.tileset_select && tile.source_row == '0 &&
			tile.source_col == '0 && tile.screen_x == '0 && tile.screen_y == '0)
		else $error("hidden tile with nonzero fields");

	// the divider remainder stays below the column count
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		tile_valid |-> tile.source_col < step_s[DIV_STEPS-1].cols)
		else $error("source column not below column count");

	// an empty output stage never back-pressures the input
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!step_vld_s[DIV_STEPS-1] |-> !cell_stall)
		else $error("input stalled with empty output stage");
`endif

endmodule

>>> tb/ttc_checker.sv
// Checker for the tile id to tileset coordinate block: shadows registers, predicts, compares.
`timescale 1ns / 1ps

module ttc_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cell_valid,
	input  logic                       cell_stall,
	input  ttc_pkg::cell_t             map_cell,
	input  logic                       tile_valid,
	input  logic                       tile_stall,
	input  ttc_pkg::tile_t             tile,
	input  logic                       cfg_we,
	input  ttc_pkg::cfg_reg_t          cfg_index,
	input  logic [ttc_pkg::CFG_W-1:0]  cfg_data,
	output int                         errors,
	output int                         pending,
	output int                         tiles_seen,
	output int                         tiles_drawn,
	output int                         tiles_second
);

	typedef struct packed {
		logic [7:0]  base_cols;
		logic [7:0]  base_size;
		logic        sec_en;
		logic [15:0] sec_first;
		logic [15:0] sec_last;
		logic [15:0] sec_count;
		logic [7:0]  sec_cols;
		logic [7:0]  sec_size;
	} tilesets_t;

	tilesets_t ts;
	ttc_pkg::tile_t tiles_due[$];
	int err_n = 0;
	int seen_n = 0;
	int drawn_n = 0;
	int second_n = 0;

	// source tile and screen position for one map cell under the given tilesets
	function automatic ttc_pkg::tile_t tile_for_cell(ttc_pkg::cell_t c, tilesets_t t);
		ttc_pkg::tile_t r;
		int num;
		int cols;
		int row;
		int col;
		logic [7:0] size;
		logic sel;
		r = '0;
		if (c.tile_id == 0)
			return r;
		num = c.tile_id;
		cols = t.base_cols;
		size = t.base_size;
		sel = 1'b0;
		// strictly inside the second tileset's id range: remap into it
		if (t.sec_en && c.tile_id > t.sec_first && c.tile_id < t.sec_last) begin
			num = int'(c.tile_id) + int'(t.sec_count) - int'(t.sec_last);
			cols = t.sec_cols;
			size = t.sec_size;
			sel = 1'b1;
		end
		if (cols == 0 || num <= 0)
			return r;
		row = num / cols;
		col = num - row * cols;
		// ids count from 1, so the last column wraps back one row
		if (col == 0) begin
			row = row - 1;
			col = cols - 1;
		end else begin
			col = col - 1;
		end
		r.visible = 1'b1;
		r.tileset_select = sel;
		r.source_row = row[15:0];
		r.source_col = col[7:0];
		r.screen_x = 16'(c.map_col) * 16'(size);
		r.screen_y = 16'(c.map_row) * 16'(size);
		return r;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_n++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		ttc_pkg::tile_t want;
		if (!arst_n) begin
			ts = '0;
			ts.base_cols = 8'd1;
			ts.base_size = 8'd16;
			ts.sec_cols = 8'd1;
			ts.sec_size = 8'd16;
			tiles_due.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				ttc_pkg::REG_BASE_COLUMNS:      ts.base_cols = cfg_data[7:0];
				ttc_pkg::REG_BASE_TILE_SIZE:    ts.base_size = cfg_data[7:0];
				ttc_pkg::REG_SECOND_ENABLE:     ts.sec_en = cfg_data[0];
				ttc_pkg::REG_SECOND_FIRST_ID:   ts.sec_first = cfg_data[15:0];
				ttc_pkg::REG_SECOND_LAST_ID:    ts.sec_last = cfg_data[15:0];
				ttc_pkg::REG_SECOND_TILE_COUNT: ts.sec_count = cfg_data[15:0];
				ttc_pkg::REG_SECOND_COLUMNS:    ts.sec_cols = cfg_data[7:0];
				ttc_pkg::REG_SECOND_TILE_SIZE:  ts.sec_size = cfg_data[7:0];
				default: ;
				endcase
			end
			if (cell_valid && !cell_stall)
				tiles_due.push_back(tile_for_cell(map_cell, ts));
			if (tile_valid && !tile_stall) begin
				seen_n++;
				if (tiles_due.size() == 0) begin
					$error("tile transfer with no cell outstanding: %h", tile);
					err_n++;
				end else begin
					want = tiles_due.pop_front();
					check_field("visible", want.visible, tile.visible);
					check_field("tileset_select", want.tileset_select, tile.tileset_select);
					check_field("source_row", want.source_row, tile.source_row);
					check_field("source_col", want.source_col, tile.source_col);
					check_field("screen_x", want.screen_x, tile.screen_x);
					check_field("screen_y", want.screen_y, tile.screen_y);
					if (want.visible)
						drawn_n++;
					if (want.tileset_select)
						second_n++;
				end
			end
		end
		errors <= err_n;
		pending <= tiles_due.size();
		tiles_seen <= seen_n;
		tiles_drawn <= drawn_n;
		tiles_second <= second_n;
	end

endmodule

>>> tb/tb_top.sv
// Testbench top: clock, reset, register programming, cell stimulus, output stalls, verdict.
`timescale 1ns / 1ps

module tb_top;
	import ttc_pkg::*;

	// longest legal quiet stretch is a sender gap, an output stall or the drain pause
	localparam int IDLE_LIMIT = 1000;
	// extra wait once the pipeline has drained, before touching registers
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_PHASES = 8;
	localparam int CELLS_PER_PHASE = 150;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cell_valid = 1'b0;
	logic             cell_stall;
	cell_t            map_cell = '0;
	logic             tile_valid;
	logic             tile_stall = 1'b0;
	tile_t            tile;
	logic             cfg_we = 1'b0;
	cfg_reg_t         cfg_index = REG_BASE_COLUMNS;
	logic [CFG_W-1:0] cfg_data = '0;

	int errors;
	int pending;
	int tiles_seen;
	int tiles_drawn;
	int tiles_second;

	// quiet: no sender gaps and no output stalls for the current phase
	logic quiet = 1'b0;
	int idle_cycles = 0;
	int settings_used = 0;
	int stall_left = 0;
	// stimulus copy of the id range and base columns, used to aim the ids
	int cur_first = 0;
	int cur_last = 0;
	int cur_base_cols = 1;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	tile_id_to_tileset_coords dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cell_valid (cell_valid),
		.cell_stall (cell_stall),
		.map_cell   (map_cell),
		.tile_valid (tile_valid),
		.tile_stall (tile_stall),
		.tile       (tile),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	ttc_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cell_valid   (cell_valid),
		.cell_stall   (cell_stall),
		.map_cell     (map_cell),
		.tile_valid   (tile_valid),
		.tile_stall   (tile_stall),
		.tile         (tile),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.errors       (errors),
		.pending      (pending),
		.tiles_seen   (tiles_seen),
		.tiles_drawn  (tiles_drawn),
		.tiles_second (tiles_second)
	);

	// Output side: after each tile transfer, draw a random stall length.
	// The stall runs on its own clock count, so it lands on every pipeline phase.
	always @(posedge clk) begin : tile_backpressure
		int hold;
		if (tile_valid && !tile_stall) begin
			hold = quiet ? 0 : $urandom_range(0, 19);
			stall_left <= hold;
			tile_stall <= (hold != 0);
		end else if (stall_left > 1) begin
			stall_left <= stall_left - 1;
		end else begin
			stall_left <= 0;
			tile_stall <= 1'b0;
		end
	end

	// Watchdog: a run of cycles with no transfer and no register write means a hang.
	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((cell_valid && !cell_stall) || (tile_valid && !tile_stall) || cfg_we) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("Watchdog: no transfer for %0d cycles, %0d tiles outstanding",
					idle_cycles, pending);
				$display("tile_id_to_tileset_coords verification failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Drop valid, let every outstanding tile come out, then let the pipe settle.
	// pending is registered in the checker, so step the clock before looking at it.
	task automatic wait_drained();
		cell_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input int val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_W-1:0];
		@(posedge clk);
	endtask

	// Full register set; only called with the block idle.
	task automatic program_tilesets(input int base_cols, input int base_size, input int sec_en,
		input int first, input int last, input int count, input int sec_cols,
		input int sec_size);
		wait_drained();
		write_reg(REG_BASE_COLUMNS, base_cols);
		write_reg(REG_BASE_TILE_SIZE, base_size);
		write_reg(REG_SECOND_ENABLE, sec_en);
		write_reg(REG_SECOND_FIRST_ID, first);
		write_reg(REG_SECOND_LAST_ID, last);
		write_reg(REG_SECOND_TILE_COUNT, count);
		write_reg(REG_SECOND_COLUMNS, sec_cols);
		write_reg(REG_SECOND_TILE_SIZE, sec_size);
		cfg_we <= 1'b0;
		cur_first = first;
		cur_last = last;
		cur_base_cols = base_cols;
		settings_used++;
	endtask

	// One cell transfer. A zero gap keeps valid high straight into the next cell.
	task automatic send_cell(input int id, input int row, input int col);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			cell_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cell_valid <= 1'b1;
		map_cell <= '{tile_id: id[15:0], map_row: row[7:0], map_col: col[7:0]};
		@(posedge clk);
		while (cell_stall)
			@(posedge clk);
	endtask

	// Ids aimed at the interesting spots: empty, the remap range and its edges,
	// last-column boundaries of the first tileset, and anything at all.
	task automatic send_random_cell();
		int id;
		case ($urandom_range(0, 9))
		0: id = 0;
		1, 2, 3: begin
			if (cur_last - cur_first >= 2)
				id = $urandom_range(cur_first + 1, cur_last - 1);
			else
				id = $urandom_range(1, 65535);
		end
		4: begin
			case ($urandom_range(0, 3))
			0: id = cur_first;
			1: id = cur_first + 1;
			2: id = cur_last - 1;
			default: id = cur_last;
			endcase
		end
		5: id = cur_base_cols * $urandom_range(0, 64) + $urandom_range(0, 1);
		default: id = $urandom_range(0, 65535);
		endcase
		if (id < 0)
			id = 0;
		if (id > 65535)
			id = 65535;
		send_cell(id, $urandom_range(0, 255), $urandom_range(0, 255));
	endtask

	// column count: zero now and then, small counts for frequent wraps, extremes
	function automatic int draw_columns();
		case ($urandom_range(0, 7))
		0: return 0;
		1: return 1;
		2: return 255;
		3, 4: return $urandom_range(2, 16);
		default: return $urandom_range(0, 255);
		endcase
	endfunction

	function automatic int draw_size();
		case ($urandom_range(0, 5))
		0: return 0;
		1: return 1;
		2: return 255;
		default: return $urandom_range(0, 255);
		endcase
	endfunction

	task automatic program_random_tilesets();
		int first;
		int last;
		int count;
		first = $urandom_range(0, 65535);
		case ($urandom_range(0, 5))
		0: begin
			first = 0;
			last = 65535;
		end
		1: last = first + $urandom_range(0, 3);
		2: last = $urandom_range(0, first);
		default: last = first + $urandom_range(2, 4000);
		endcase
		if (last > 65535)
			last = 65535;
		// mostly near a consistent tile count, where remapped ids start at 1; sometimes arbitrary
		if ($urandom_range(0, 3) == 0)
			count = $urandom_range(0, 65535);
		else
			count = last - first - 1 + $urandom_range(0, 8) - 4;
		if (count < 0)
			count = 0;
		if (count > 65535)
			count = 65535;
		program_tilesets(draw_columns(), draw_size(), ($urandom_range(0, 4) != 0),
			first, last, count, draw_columns(), draw_size());
	endtask

	initial begin : stimulus
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: one column, second tileset off
		send_cell(1, 0, 0);
		send_cell(65535, 255, 255);
		send_cell(0, 255, 255);

		// five-column first tileset; second tileset spans ids 101..199
		program_tilesets(5, 255, 1, 100, 200, 50, 255, 1);
		send_cell(0, 255, 255);     // empty cell
		send_cell(1, 0, 0);
		send_cell(5, 1, 2);         // last column wraps back a row
		send_cell(6, 255, 0);
		send_cell(100, 3, 3);       // equal to first id: stays in first tileset
		send_cell(101, 4, 4);       // remaps below zero: not drawn
		send_cell(150, 5, 5);       // remaps to zero: not drawn
		send_cell(151, 255, 255);   // remaps to one
		send_cell(199, 7, 7);
		send_cell(200, 8, 8);       // equal to last id: stays in first tileset
		send_cell(65535, 255, 255);

		// zero tile size on the first tileset, zero columns on the second
		program_tilesets(255, 0, 1, 1000, 1010, 65535, 0, 255);
		send_cell(255, 255, 255);
		send_cell(256, 1, 1);
		send_cell(1005, 2, 2);

		// zero columns on the first tileset; second covers almost every id
		program_tilesets(0, 1, 1, 0, 65535, 65535, 1, 255);
		send_cell(7, 3, 3);
		send_cell(1, 255, 255);
		send_cell(65534, 255, 255);
		send_cell(65535, 0, 0);

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase == 0)
				program_tilesets(255, 255, 1, 0, 65535, 65535, 255, 255);
			else if (phase == 1)
				program_tilesets(1, 1, 1, 65535, 0, 0, 1, 1);
			else
				program_random_tilesets();
			quiet <= (phase % 3 == 2);
			for (int n = 0; n < CELLS_PER_PHASE; n++)
				send_random_cell();
		end

		wait_drained();
		$display("Checked %0d tiles (%0d drawn, %0d from the second tileset)",
			tiles_seen, tiles_drawn, tiles_second);
		$display("under %0d register settings, with random gaps and stalls up to 19 cycles.",
			settings_used);
		if (errors == 0)
			$display("tile_id_to_tileset_coords verification clean");
		else
			$display("tile_id_to_tileset_coords verification failed");
		$finish;
	end

endmodule
